// ===== hw/rtl/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation block.
// Used by bsc_mul, bsc_div and barometric_sensor_compensation_top.
package bsc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgTempCalib = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPressA    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPressB    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPressC    = 2'd3;

  localparam logic KindTemp  = 1'b0;
  localparam logic KindPress = 1'b1;

  // Sequencer steps, one shared multiply each.
  localparam logic [3:0] UcTempA  = 4'd0;
  localparam logic [3:0] UcTempD  = 4'd1;
  localparam logic [3:0] UcTempT3 = 4'd2;
  localparam logic [3:0] UcSq     = 4'd3;
  localparam logic [3:0] UcP6     = 4'd4;
  localparam logic [3:0] UcP5     = 4'd5;
  localparam logic [3:0] UcP3     = 4'd6;
  localparam logic [3:0] UcP2     = 4'd7;
  localparam logic [3:0] UcP1     = 4'd8;
  localparam logic [3:0] UcScale  = 4'd9;
  localparam logic [3:0] UcP9     = 4'd10;
  localparam logic [3:0] UcQq     = 4'd11;
  localparam logic [3:0] UcP8     = 4'd12;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_OUT   = 6'b100000
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } op_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] value;
  } op_rsp_t;

endpackage

// ===== hw/rtl/bsc_mul.sv =====
// 64 x 64 multiplier, product modulo 2^64, from one 32 x 32 multiplier reused across the partial products.
// Depends on bsc_pkg.
module bsc_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsc_pkg::op_req_t req_i,
  output bsc_pkg::op_rsp_t rsp_o
);

  logic [63:0] a_q, b_q, pp_q, acc_q;
  logic [1:0]  ph_q;
  logic        busy_q, done_q;
  logic [31:0] ma, mb;

  always_comb begin
    case (ph_q)
      2'd0: begin ma = a_q[31:0];  mb = b_q[31:0];  end
      2'd1: begin ma = a_q[31:0];  mb = b_q[63:32]; end
      2'd2: begin ma = a_q[63:32]; mb = b_q[31:0];  end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      pp_q <= {32'b0, ma} * {32'b0, mb};
      case (ph_q)
        2'd1:    acc_q <= pp_q;
        2'd2:    acc_q <= acc_q + {pp_q[31:0], 32'b0};
        2'd3:    acc_q <= acc_q + {pp_q[31:0], 32'b0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

// ===== hw/rtl/bsc_div.sv =====
// Signed 64-bit divider truncating toward zero, one quotient bit per cycle.
// Depends on bsc_pkg. Divisor must be nonzero.
module bsc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsc_pkg::op_req_t req_i,
  output bsc_pkg::op_rsp_t rsp_o
);

  logic [63:0] quo_q, rem_q, den_q;
  logic        neg_q, busy_q, fin_q, done_q;
  logic [5:0]  cnt_q;
  logic [64:0] shifted, diff;

  assign shifted = {rem_q, quo_q[63]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[63] ^ req_i.b[63];
      quo_q <= req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
      den_q <= req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end else if (fin_q) begin
      quo_q <= neg_q ? (64'd0 - quo_q) : quo_q;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = quo_q;

endmodule

// ===== hw/rtl/barometric_sensor_compensation_top.sv =====
// Barometric sensor compensation: sequencer and datapath around a shared multiplier and divider.
// Depends on bsc_pkg, bsc_mul, bsc_div.
//
// Usage:
//   Input stream s_axis: tuser = kind (0 temperature, 1 pressure), tdata = raw 20-bit sample.
//   Output stream m_axis: tuser = result kind, tdata = temperature, pressure, divide flag.
//   Calibration words are written on cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only
//   while idle, as the block does not enforce it. One item at a time: s_axis_tready is high
//   only when the sequencer is idle. Every multiply runs on one 32x32 multiplier.
//   A temperature item takes three multiplies. A pressure item takes ten multiplies plus a
//   bit-serial divide; a zero divisor skips the divide and the multiplies after it.
//   The result sits in an output register; a stalled receiver holds the next result
//   in the sequencer until the register frees, and no new item is taken meanwhile.
//   Reset clears calibration, the stored fine temperature (to 0) and all valids.
module barometric_sensor_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] raw_sample, rest zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] temperature_centi, [63:32] pressure_q24_8,
                                      // [64] divide_by_zero, rest zero
  output logic        m_axis_tuser,   // [0] result_kind
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [47:0] tcal_q;
  logic [63:0] pca_q, pcb_q;
  logic [15:0] pcc_q;
  logic [31:0] fine_q;

  bsc_pkg::seq_state_e state_q;
  logic [3:0]  uc_q;
  logic        kind_q;
  logic [19:0] adc_q;
  logic [63:0] x_q, s_q, v2_q, w_q, p_q;
  logic [31:0] res_t_q, res_p_q;
  logic        dbz_q;
  logic [71:0] m_data_q;
  logic        m_kind_q, m_valid_q;

  bsc_pkg::op_req_t mul_req, div_req;
  bsc_pkg::op_rsp_t mul_rsp, div_rsp;

  logic        accept;
  logic [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] a32, d32, fine_new, f5, t_res;
  logic [63:0] prod, p0, n_pre, q13, v1_new, fin_sum, fin_r;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == bsc_pkg::ST_IDLE);

  assign t2 = {{48{tcal_q[31]}}, tcal_q[31:16]};
  assign t3 = {{48{tcal_q[47]}}, tcal_q[47:32]};
  assign p1 = {48'b0, pca_q[15:0]};
  assign p2 = {{48{pca_q[31]}}, pca_q[31:16]};
  assign p3 = {{48{pca_q[47]}}, pca_q[47:32]};
  assign p4 = {{48{pca_q[63]}}, pca_q[63:48]};
  assign p5 = {{48{pcb_q[15]}}, pcb_q[15:0]};
  assign p6 = {{48{pcb_q[31]}}, pcb_q[31:16]};
  assign p7 = {{48{pcb_q[47]}}, pcb_q[47:32]};
  assign p8 = {{48{pcb_q[63]}}, pcb_q[63:48]};
  assign p9 = {{48{pcc_q[15]}}, pcc_q};

  assign prod  = mul_rsp.value;
  assign a32   = 32'(adc_q >> 3) - {15'b0, tcal_q[15:0], 1'b0};
  assign d32   = 32'(adc_q >> 4) - {16'b0, tcal_q[15:0]};
  assign fine_new = x_q[31:0] + 32'($signed(prod[31:0]) >>> 14);
  assign f5    = (fine_new << 2) + fine_new + 32'd128;
  assign t_res = 32'($signed(f5) >>> 8);
  assign p0    = 64'd1048576 - {44'b0, adc_q};
  assign n_pre = (p0 << 31) - v2_q;
  assign q13   = 64'($signed(p_q) >>> 13);
  assign v1_new = 64'($signed(prod) >>> 33);
  assign fin_sum = p_q + w_q + v2_q;
  assign fin_r = 64'($signed(fin_sum) >>> 8) + (p7 << 4);

  always_comb begin
    mul_req.start = (state_q == bsc_pkg::ST_ISSUE);
    case (uc_q)
      bsc_pkg::UcTempA:  begin mul_req.a = {{32{a32[31]}}, a32}; mul_req.b = t2; end
      bsc_pkg::UcTempD:  begin mul_req.a = {{32{d32[31]}}, d32}; mul_req.b = {{32{d32[31]}}, d32}; end
      bsc_pkg::UcTempT3: begin mul_req.a = w_q; mul_req.b = t3; end
      bsc_pkg::UcSq:     begin mul_req.a = x_q; mul_req.b = x_q; end
      bsc_pkg::UcP6:     begin mul_req.a = s_q; mul_req.b = p6; end
      bsc_pkg::UcP5:     begin mul_req.a = x_q; mul_req.b = p5; end
      bsc_pkg::UcP3:     begin mul_req.a = s_q; mul_req.b = p3; end
      bsc_pkg::UcP2:     begin mul_req.a = x_q; mul_req.b = p2; end
      bsc_pkg::UcP1:     begin mul_req.a = w_q; mul_req.b = p1; end
      bsc_pkg::UcScale:  begin mul_req.a = n_pre; mul_req.b = 64'd3125; end
      bsc_pkg::UcP9:     begin mul_req.a = p9; mul_req.b = q13; end
      bsc_pkg::UcQq:     begin mul_req.a = w_q; mul_req.b = q13; end
      bsc_pkg::UcP8:     begin mul_req.a = p8; mul_req.b = p_q; end
      default:           begin mul_req.a = '0; mul_req.b = '0; end
    endcase
    div_req.start = (state_q == bsc_pkg::ST_WAIT) && mul_rsp.done
                    && (uc_q == bsc_pkg::UcScale);
    div_req.a = prod;
    div_req.b = x_q;
  end

  bsc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  bsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0;
      pca_q  <= '0;
      pcb_q  <= '0;
      pcc_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsc_pkg::CfgTempCalib: tcal_q <= cfg_data_i[47:0];
        bsc_pkg::CfgPressA:    pca_q  <= cfg_data_i;
        bsc_pkg::CfgPressB:    pcb_q  <= cfg_data_i;
        bsc_pkg::CfgPressC:    pcc_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bsc_pkg::ST_IDLE;
      uc_q      <= '0;
      fine_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == bsc_pkg::ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        bsc_pkg::ST_IDLE: begin
          if (accept) begin
            uc_q    <= (s_axis_tuser == bsc_pkg::KindPress) ? bsc_pkg::UcSq
                                                           : bsc_pkg::UcTempA;
            state_q <= bsc_pkg::ST_ISSUE;
          end
        end
        bsc_pkg::ST_ISSUE: state_q <= bsc_pkg::ST_WAIT;
        bsc_pkg::ST_WAIT: begin
          if (mul_rsp.done) begin
            uc_q    <= uc_q + 4'd1;
            state_q <= bsc_pkg::ST_ISSUE;
            case (uc_q)
              bsc_pkg::UcTempT3: begin
                fine_q  <= fine_new;
                state_q <= bsc_pkg::ST_OUT;
              end
              bsc_pkg::UcP1: if (v1_new == 64'd0) state_q <= bsc_pkg::ST_OUT;
              bsc_pkg::UcScale: state_q <= bsc_pkg::ST_DIV;
              bsc_pkg::UcP8:    state_q <= bsc_pkg::ST_FIN;
              default: ;
            endcase
          end
        end
        bsc_pkg::ST_DIV: if (div_rsp.done) state_q <= bsc_pkg::ST_ISSUE;
        bsc_pkg::ST_FIN: state_q <= bsc_pkg::ST_OUT;
        bsc_pkg::ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= bsc_pkg::ST_IDLE;
          end
        end
        default: state_q <= bsc_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bsc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_q  <= s_axis_tuser;
          adc_q   <= s_axis_tdata[19:0];
          x_q     <= {{32{fine_q[31]}}, fine_q} - 64'd128000;
          res_t_q <= '0;
          res_p_q <= '0;
          dbz_q   <= 1'b0;
        end
      end
      bsc_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          case (uc_q)
            bsc_pkg::UcTempA:  x_q <= {{32{prod[31]}}, 32'($signed(prod[31:0]) >>> 11)};
            bsc_pkg::UcTempD:  w_q <= {{32{prod[31]}}, 32'($signed(prod[31:0]) >>> 12)};
            bsc_pkg::UcTempT3: res_t_q <= t_res;
            bsc_pkg::UcSq:     s_q <= prod;
            bsc_pkg::UcP6:     v2_q <= prod;
            bsc_pkg::UcP5:     v2_q <= v2_q + (prod << 17) + (p4 << 35);
            bsc_pkg::UcP3:     w_q <= 64'($signed(prod) >>> 8);
            bsc_pkg::UcP2:     w_q <= 64'h0000_8000_0000_0000 + w_q + (prod << 12);
            bsc_pkg::UcP1: begin
              x_q <= v1_new;
              if (v1_new == 64'd0) dbz_q <= 1'b1;
            end
            bsc_pkg::UcP9:     w_q <= prod;
            bsc_pkg::UcQq:     w_q <= 64'($signed(prod) >>> 25);
            bsc_pkg::UcP8:     v2_q <= 64'($signed(prod) >>> 19);
            default: ;
          endcase
        end
      end
      bsc_pkg::ST_DIV: if (div_rsp.done) p_q <= div_rsp.value;
      bsc_pkg::ST_FIN: begin
        if (fin_r[63])            res_p_q <= '0;
        else if (|fin_r[62:32])   res_p_q <= 32'hFFFF_FFFF;
        else                      res_p_q <= fin_r[31:0];
      end
      bsc_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_kind_q <= kind_q;
          m_data_q <= {7'b0, dbz_q, res_p_q, res_t_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

endmodule
